// File: hw/rtl/rrt_pkg.sv
`default_nettype none

package rrt_pkg;

  // event codes
  localparam logic [2:0] OP_ADVERT    = 3'd0;
  localparam logic [2:0] OP_REQUEST   = 3'd1;
  localparam logic [2:0] OP_PACKET    = 3'd2;
  localparam logic [2:0] OP_FWD_TIMER = 3'd3;
  localparam logic [2:0] OP_REQ_TIMER = 3'd4;

  // result action codes
  localparam logic [1:0] ACT_NONE     = 2'd0;
  localparam logic [1:0] ACT_ADVERT   = 2'd1;
  localparam logic [1:0] ACT_REQUEST  = 2'd2;
  localparam logic [1:0] ACT_DECISION = 2'd3;

  // routing decision codes
  localparam logic [1:0] DEC_LOCAL     = 2'd0;
  localparam logic [1:0] DEC_BROADCAST = 2'd1;
  localparam logic [1:0] DEC_UNICAST   = 2'd2;
  localparam logic [1:0] DEC_DROP      = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_LOCAL_ADDR  = 3'd0;
  localparam logic [2:0] REG_REQ_NEXTHOP = 3'd1;
  localparam logic [2:0] REG_MAX_HOPS    = 3'd2;
  localparam logic [2:0] REG_VALID_TICKS = 3'd3;

  // special addresses
  localparam logic [15:0] ADDR_BROADCAST  = 16'hFFFF;
  localparam logic [15:0] ADDR_ROOT_ALIAS = 16'hFFFE;

  // reset values
  localparam logic [7:0]  MAX_HOPS_RST    = 8'd16;
  localparam logic [30:0] VALID_TICKS_RST = 31'd100000;
  localparam logic [7:0]  HOPS_RST        = 8'd255;

  typedef struct packed {
    logic [15:0] local_addr;
    logic [15:0] required_nexthop;
    logic [7:0]  max_hops;
    logic [30:0] valid_ticks;
  } rrt_cfg_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] now;
    logic [15:0] src_addr;
    logic        adv_complete;
    logic [15:0] adv_root;
    logic [7:0]  adv_hops;
    logic [15:0] adv_seq;
    logic [31:0] adv_root_clock;
    logic [15:0] dst_addr;
    logic        from_self;
    logic [7:0]  hop_limit;
    logic [15:0] immed_dst;
  } rrt_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  decision;
    logic [15:0] next_hop;
    logic [15:0] dst_out;
    logic [7:0]  hop_limit_out;
    logic [15:0] send_root;
    logic [7:0]  send_hops;
    logic [15:0] send_seq;
    logic [31:0] send_root_clock;
    logic        arm_forward;
    logic        rearm_forward;
  } rrt_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/rrt_cfg_regs.sv
`default_nettype none

module rrt_cfg_regs (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire logic [2:0]      wr_index,
  input  wire logic [31:0]     wr_data,
  output rrt_pkg::rrt_cfg_t    cfg
);
  import rrt_pkg::*;

  rrt_cfg_t cfg_r;
  rrt_cfg_t cfg_nxt;

  // register write decode, indexes beyond the list are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_LOCAL_ADDR:  cfg_nxt.local_addr       = wr_data[15:0];
        REG_REQ_NEXTHOP: cfg_nxt.required_nexthop = wr_data[15:0];
        REG_MAX_HOPS:    cfg_nxt.max_hops         = wr_data[7:0];
        REG_VALID_TICKS: cfg_nxt.valid_ticks      = wr_data[30:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_addr       <= '0;
      cfg_r.required_nexthop <= '0;
      cfg_r.max_hops         <= MAX_HOPS_RST;
      cfg_r.valid_ticks      <= VALID_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: hw/rtl/rrt_route_core.sv
`default_nettype none

module rrt_route_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  rrt_pkg::rrt_cfg_t       cfg,
  input  rrt_pkg::rrt_item_t      item,
  output rrt_pkg::rrt_result_t    res
);
  import rrt_pkg::*;

  // route state
  logic        have_route_r, have_route_nxt;
  logic [31:0] adopt_time_r, adopt_time_nxt;
  logic [15:0] last_seq_r, last_seq_nxt;
  logic [7:0]  hops_r, hops_nxt;
  logic [15:0] nh_reg_r, nh_reg_nxt;
  logic [15:0] root_reg_r, root_reg_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic        fwd_pend_r, fwd_pend_nxt;

  logic [31:0] expiry;
  logic [31:0] age_diff;
  logic        route_ok;
  logic [15:0] seq_diff;
  logic        seq_newer;
  logic        sender_bad;
  logic        adopt;
  logic        is_root_alias;
  logic [15:0] dst;
  logic [7:0]  hl;
  logic [7:0]  hl_dec;
  rrt_result_t r;

  // route freshness in wrapping time
  assign expiry   = adopt_time_r + {1'b0, cfg.valid_ticks};
  assign age_diff = item.now - expiry;
  assign route_ok = have_route_r && age_diff[31];

  assign seq_diff  = last_seq_r - item.adv_seq;
  assign seq_newer = seq_diff[15];

  assign sender_bad = (cfg.required_nexthop != 16'd0) &&
                      (item.src_addr != cfg.required_nexthop);

  // advertisement acceptance
  assign adopt = item.adv_complete && (item.adv_hops <= cfg.max_hops) &&
                 (!route_ok || seq_newer ||
                  ((item.adv_seq == last_seq_r) && (item.adv_hops < hops_r)));

  // root alias rewrite for local packets
  assign is_root_alias = item.from_self && (item.dst_addr == ADDR_ROOT_ALIAS);
  assign dst    = is_root_alias ? root_reg_r : item.dst_addr;
  assign hl     = is_root_alias ? cfg.max_hops : item.hop_limit;
  assign hl_dec = hl - 8'd1;

  always_comb begin
    have_route_nxt = have_route_r;
    adopt_time_nxt = adopt_time_r;
    last_seq_nxt   = last_seq_r;
    hops_nxt       = hops_r;
    nh_reg_nxt     = nh_reg_r;
    root_reg_nxt   = root_reg_r;
    offset_nxt     = offset_r;
    fwd_pend_nxt   = fwd_pend_r;
    r              = '0;

    unique case (item.operation)
      OP_REQUEST: begin
        if (!sender_bad && !fwd_pend_r) begin
          fwd_pend_nxt  = 1'b1;
          r.arm_forward = 1'b1;
        end
      end
      OP_ADVERT: begin
        if (!sender_bad && adopt) begin
          root_reg_nxt   = item.adv_root;
          nh_reg_nxt     = item.src_addr;
          last_seq_nxt   = item.adv_seq;
          hops_nxt       = item.adv_hops;
          adopt_time_nxt = item.now;
          have_route_nxt = 1'b1;
          offset_nxt     = item.adv_root_clock - item.now;
          if (!fwd_pend_r) begin
            fwd_pend_nxt  = 1'b1;
            r.arm_forward = 1'b1;
          end
        end
      end
      OP_PACKET: begin
        r.action        = ACT_DECISION;
        r.next_hop      = item.immed_dst;
        r.dst_out       = dst;
        r.hop_limit_out = hl;
        priority if (dst == cfg.local_addr) begin
          r.decision = DEC_LOCAL;
        end else if (dst == ADDR_BROADCAST) begin
          r.decision = item.from_self ? DEC_BROADCAST : DEC_LOCAL;
        end else begin
          // forwarded packets lose one hop of their limit
          if (!item.from_self && (hl != 8'd0)) begin
            r.hop_limit_out = hl_dec;
          end
          priority if (!item.from_self && (hl == 8'd1)) begin
            r.decision = DEC_DROP;
          end else if (dst == root_reg_r) begin
            priority if (!route_ok) begin
              r.decision = DEC_DROP;
            end else if (!item.from_self && (cfg.required_nexthop != 16'd0) &&
                         (item.immed_dst != cfg.local_addr)) begin
              r.decision = DEC_DROP;
            end else begin
              r.next_hop = nh_reg_r;
              r.decision = DEC_UNICAST;
            end
          end else begin
            r.decision = item.from_self ? DEC_UNICAST : DEC_DROP;
          end
        end
      end
      OP_FWD_TIMER: begin
        if (hops_r < cfg.max_hops) begin
          r.action          = ACT_ADVERT;
          r.send_root       = root_reg_r;
          r.send_hops       = hops_r + 8'd1;
          r.send_seq        = last_seq_r;
          r.send_root_clock = item.now + offset_r;
          fwd_pend_nxt      = 1'b0;
        end
      end
      OP_REQ_TIMER: begin
        if (!route_ok) begin
          r.action     = ACT_REQUEST;
          fwd_pend_nxt = 1'b0;
        end
      end
      default: begin
        r = '0;
      end
    endcase
  end

  // state update only when an item is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_route_r <= 1'b0;
      adopt_time_r <= '0;
      last_seq_r   <= '0;
      hops_r       <= HOPS_RST;
      nh_reg_r     <= '0;
      root_reg_r   <= '0;
      offset_r     <= '0;
      fwd_pend_r   <= 1'b0;
    end else if (fire) begin
      have_route_r <= have_route_nxt;
      adopt_time_r <= adopt_time_nxt;
      last_seq_r   <= last_seq_nxt;
      hops_r       <= hops_nxt;
      nh_reg_r     <= nh_reg_nxt;
      root_reg_r   <= root_reg_nxt;
      offset_r     <= offset_nxt;
      fwd_pend_r   <= fwd_pend_nxt;
    end
  end

  assign res = r;

endmodule

`default_nettype wire

// File: hw/rtl/root_route_tracker.sv
// root_route_tracker: tracks one route toward a root node
//
// input channel: in_valid/in_stall with one event per transfer (advert,
// route request, packet to route, forward timer, request timer) and the
// current tick time in in_now. a transfer happens when valid is high and
// stall is low.
// result channel: out_valid/out_stall, exactly one result per event, in
// order. fields not belonging to the reported action are zero.
// config channel: cfg_valid/cfg_ready, always ready; cfg_index picks the
// register (local address, required next hop, max hops, valid ticks).
// write only while no event is in flight.
// flow: a taken event waits in the input register, the route core works on it
// combinationally, and its result is captured in the result register when the
// input register advances, and is then shown on the out_ ports.
// throughput: one event per cycle without receiver stall; the route state update
// is a single compare-and-update pass between the input and result registers.
// receiver stall: the result register holds; the input register keeps one
// further event and in_stall rises only when both are full.
// reset: route forgotten, hop count 255, registers at their defaults,
// both pipeline registers empty.
`default_nettype none

module root_route_tracker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // event input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_operation,
  input  wire logic [31:0] in_now,
  input  wire logic [15:0] in_src_addr,
  input  wire logic        in_adv_complete,
  input  wire logic [15:0] in_adv_root,
  input  wire logic [7:0]  in_adv_hops,
  input  wire logic [15:0] in_adv_seq,
  input  wire logic [31:0] in_adv_root_clock,
  input  wire logic [15:0] in_dst_addr,
  input  wire logic        in_from_self,
  input  wire logic [7:0]  in_hop_limit,
  input  wire logic [15:0] in_immed_dst,
  // result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_action,
  output logic [1:0]       out_decision,
  output logic [15:0]      out_next_hop,
  output logic [15:0]      out_dst_out,
  output logic [7:0]       out_hop_limit_out,
  output logic [15:0]      out_send_root,
  output logic [7:0]       out_send_hops,
  output logic [15:0]      out_send_seq,
  output logic [31:0]      out_send_root_clock,
  output logic             out_arm_forward,
  output logic             out_rearm_forward,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import rrt_pkg::*;

  rrt_cfg_t    cfg;
  rrt_item_t   item_r;
  logic        item_vld_r, item_vld_nxt;
  logic        res_vld_r, res_vld_nxt;
  rrt_result_t res_r;
  rrt_result_t res;
  logic        advance;
  logic        in_xfer;

  assign cfg_ready = 1'b1;

  rrt_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // pipeline handshake
  assign advance  = item_vld_r && (!res_vld_r || !out_stall);
  assign in_stall = item_vld_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  assign item_vld_nxt = in_xfer || (item_vld_r && !advance);
  assign res_vld_nxt  = advance || (res_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      res_vld_r  <= res_vld_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.operation      <= in_operation;
      item_r.now            <= in_now;
      item_r.src_addr       <= in_src_addr;
      item_r.adv_complete   <= in_adv_complete;
      item_r.adv_root       <= in_adv_root;
      item_r.adv_hops       <= in_adv_hops;
      item_r.adv_seq        <= in_adv_seq;
      item_r.adv_root_clock <= in_adv_root_clock;
      item_r.dst_addr       <= in_dst_addr;
      item_r.from_self      <= in_from_self;
      item_r.hop_limit      <= in_hop_limit;
      item_r.immed_dst      <= in_immed_dst;
    end
  end

  rrt_route_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .cfg   (cfg),
    .item  (item_r),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid           = res_vld_r;
  assign out_action          = res_r.action;
  assign out_decision        = res_r.decision;
  assign out_next_hop        = res_r.next_hop;
  assign out_dst_out         = res_r.dst_out;
  assign out_hop_limit_out   = res_r.hop_limit_out;
  assign out_send_root       = res_r.send_root;
  assign out_send_hops       = res_r.send_hops;
  assign out_send_seq        = res_r.send_seq;
  assign out_send_root_clock = res_r.send_root_clock;
  assign out_arm_forward     = res_r.arm_forward;
  assign out_rearm_forward   = res_r.rearm_forward;

endmodule

`default_nettype wire

// File: hw/rtl/rrt_checker.sv
`default_nettype none

module rrt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_action,
  input wire logic [1:0]  out_decision,
  input wire logic [15:0] out_next_hop,
  input wire logic [15:0] out_send_root,
  input wire logic [31:0] out_send_root_clock,
  input wire logic        out_arm_forward,
  input wire logic        out_rearm_forward
);
  import rrt_pkg::*;

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result stays offered
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result withdrawn");

  // arming only comes from adverts and requests, which report no action
  a_arm_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_arm_forward) |-> (out_action == ACT_NONE))
    else $error("arm_forward with an action");

  // decision fields are zero outside a routing decision
  a_dec_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_action != ACT_DECISION)) |->
      ((out_decision == DEC_LOCAL) && (out_next_hop == 16'd0)))
    else $error("decision fields set outside decision");

  // advert fields and rearm_forward only with an advert
  a_adv_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_action != ACT_ADVERT)) |->
      ((out_send_root == 16'd0) && (out_send_root_clock == 32'd0) &&
       !out_rearm_forward))
    else $error("advert fields set outside advert");

endmodule

bind root_route_tracker rrt_checker u_rrt_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_action          (out_action),
  .out_decision        (out_decision),
  .out_next_hop        (out_next_hop),
  .out_send_root       (out_send_root),
  .out_send_root_clock (out_send_root_clock),
  .out_arm_forward     (out_arm_forward),
  .out_rearm_forward   (out_rearm_forward)
);

`default_nettype wire

// File: sim/tb_root_route_tracker.sv
module tb_root_route_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import rrt_pkg::*;

  // clock, reset and port signals
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  rrt_item_t   shown_ev = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_action;
  logic [1:0]  out_decision;
  logic [15:0] out_next_hop;
  logic [15:0] out_dst_out;
  logic [7:0]  out_hop_limit_out;
  logic [15:0] out_send_root;
  logic [7:0]  out_send_hops;
  logic [15:0] out_send_seq;
  logic [31:0] out_send_root_clock;
  logic        out_arm_forward;
  logic        out_rearm_forward;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  rrt_result_t seen_res;
  assign seen_res = {out_action, out_decision, out_next_hop, out_dst_out, out_hop_limit_out,
                     out_send_root, out_send_hops, out_send_seq, out_send_root_clock,
                     out_arm_forward, out_rearm_forward};

  // traffic bookkeeping
  rrt_item_t   events_to_send[$];
  rrt_result_t due_results[$];
  rrt_result_t head_res;
  logic        in_taken = 1'b0;
  int          num_sent = 0;
  int          num_taken = 0;
  int          cfg_done = 0;
  int          mismatches = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  logic        hold_ask = 1'b0;

  // predicted configuration and route state
  logic [15:0] cf_local = '0;
  logic [15:0] cf_upstream = '0;
  logic [7:0]  cf_max_hops = MAX_HOPS_RST;
  logic [30:0] cf_lifetime = VALID_TICKS_RST;
  logic        rt_have = 1'b0;
  logic [31:0] rt_since = '0;
  logic [15:0] rt_seq = '0;
  logic [7:0]  rt_hops = HOPS_RST;
  logic [15:0] rt_via = '0;
  logic [15:0] rt_root = '0;
  logic [31:0] rt_offset = '0;
  logic        fwd_armed = 1'b0;

  // stimulus shaping state
  logic [31:0] gen_tick;
  logic [15:0] gen_seq;
  logic [15:0] gen_root;
  logic [15:0] gen_peer;
  logic [15:0] plan_own;
  logic [15:0] plan_upstream;
  logic [7:0]  plan_max_hops;
  logic [30:0] plan_lifetime;

  root_route_tracker uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (shown_ev.operation),
    .in_now              (shown_ev.now),
    .in_src_addr         (shown_ev.src_addr),
    .in_adv_complete     (shown_ev.adv_complete),
    .in_adv_root         (shown_ev.adv_root),
    .in_adv_hops         (shown_ev.adv_hops),
    .in_adv_seq          (shown_ev.adv_seq),
    .in_adv_root_clock   (shown_ev.adv_root_clock),
    .in_dst_addr         (shown_ev.dst_addr),
    .in_from_self        (shown_ev.from_self),
    .in_hop_limit        (shown_ev.hop_limit),
    .in_immed_dst        (shown_ev.immed_dst),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_action          (out_action),
    .out_decision        (out_decision),
    .out_next_hop        (out_next_hop),
    .out_dst_out         (out_dst_out),
    .out_hop_limit_out   (out_hop_limit_out),
    .out_send_root       (out_send_root),
    .out_send_hops       (out_send_hops),
    .out_send_seq        (out_send_seq),
    .out_send_root_clock (out_send_root_clock),
    .out_arm_forward     (out_arm_forward),
    .out_rearm_forward   (out_rearm_forward),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // route is live while now lies before adoption time plus lifetime, wrapping
  function logic route_live(input logic [31:0] at);
    logic [31:0] gap;
    gap = at - (rt_since + {1'b0, cf_lifetime});
    return rt_have && gap[31];
  endfunction

  // sequence number a is newer than b in 16-bit wrapping order
  function logic seq_after(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = b - a;
    return d[15];
  endfunction

  // applies one event to the predicted route state and returns its result
  function rrt_result_t track_event(input rrt_item_t ev);
    rrt_result_t r;
    logic        foreign;
    logic        take;
    logic        hl_ok;
    logic [15:0] dst;
    logic [15:0] via;
    logic [7:0]  hl;
    logic [1:0]  dec;
    r = '0;
    foreign = (cf_upstream != 16'd0) && (ev.src_addr != cf_upstream);
    case (ev.operation)
      OP_REQUEST: begin
        if (!foreign && !fwd_armed) begin
          fwd_armed = 1'b1;
          r.arm_forward = 1'b1;
        end
      end
      OP_ADVERT: begin
        if (!foreign && ev.adv_complete) begin
          take = !route_live(ev.now) || seq_after(ev.adv_seq, rt_seq) ||
                 (ev.adv_seq == rt_seq && ev.adv_hops < rt_hops);
          if (ev.adv_hops > cf_max_hops) take = 1'b0;
          if (take) begin
            rt_root = ev.adv_root;
            rt_via = ev.src_addr;
            rt_seq = ev.adv_seq;
            rt_hops = ev.adv_hops;
            if (!fwd_armed) begin
              fwd_armed = 1'b1;
              r.arm_forward = 1'b1;
            end
            rt_since = ev.now;
            rt_have = 1'b1;
            rt_offset = ev.adv_root_clock - ev.now;
          end
        end
      end
      OP_PACKET: begin
        dst = ev.dst_addr;
        hl = ev.hop_limit;
        via = ev.immed_dst;
        // root alias from this node: aim at the stored root with a fresh hop limit
        if (ev.from_self && dst == ADDR_ROOT_ALIAS) begin
          dst = rt_root;
          hl = cf_max_hops;
        end
        if (dst == cf_local) begin
          dec = DEC_LOCAL;
        end else if (dst == ADDR_BROADCAST) begin
          dec = ev.from_self ? DEC_BROADCAST : DEC_LOCAL;
        end else begin
          hl_ok = 1'b1;
          if (!ev.from_self && hl != 8'd0) begin
            hl = hl - 8'd1;
            hl_ok = (hl != 8'd0);
          end
          if (!hl_ok) begin
            dec = DEC_DROP;
          end else if (dst == rt_root) begin
            if (!route_live(ev.now)) begin
              dec = DEC_DROP;
            end else if (!ev.from_self && cf_upstream != 16'd0 && ev.immed_dst != cf_local) begin
              dec = DEC_DROP;
            end else begin
              via = rt_via;
              dec = DEC_UNICAST;
            end
          end else begin
            dec = ev.from_self ? DEC_UNICAST : DEC_DROP;
          end
        end
        r.action = ACT_DECISION;
        r.decision = dec;
        r.next_hop = via;
        r.dst_out = dst;
        r.hop_limit_out = hl;
      end
      OP_FWD_TIMER: begin
        if (rt_hops < cf_max_hops) begin
          r.action = ACT_ADVERT;
          r.send_root = rt_root;
          r.send_hops = rt_hops + 8'd1;
          r.send_seq = rt_seq;
          r.send_root_clock = ev.now + rt_offset;
          fwd_armed = 1'b0;
        end
      end
      OP_REQ_TIMER: begin
        if (!route_live(ev.now)) begin
          r.action = ACT_REQUEST;
          fwd_armed = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function void check_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // event driver: offers the next queued event once the previous one has transferred
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (events_to_send.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        shown_ev <= events_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stall plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_ask) begin
      hold_left = 80;
      hold_ask = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor: register writes, result checks and prediction per transfer
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOCAL_ADDR:  cf_local = cfg_data[15:0];
          REG_REQ_NEXTHOP: cf_upstream = cfg_data[15:0];
          REG_MAX_HOPS:    cf_max_hops = cfg_data[7:0];
          REG_VALID_TICKS: cf_lifetime = cfg_data[30:0];
          default: ;
        endcase
        cfg_done++;
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result expected none actual %0h", $time, seen_res);
        end else begin
          head_res = due_results.pop_front();
          check_field("action", 32'(head_res.action), 32'(seen_res.action));
          check_field("decision", 32'(head_res.decision), 32'(seen_res.decision));
          check_field("next_hop", 32'(head_res.next_hop), 32'(seen_res.next_hop));
          check_field("dst_out", 32'(head_res.dst_out), 32'(seen_res.dst_out));
          check_field("hop_limit_out", 32'(head_res.hop_limit_out),
                      32'(seen_res.hop_limit_out));
          check_field("send_root", 32'(head_res.send_root), 32'(seen_res.send_root));
          check_field("send_hops", 32'(head_res.send_hops), 32'(seen_res.send_hops));
          check_field("send_seq", 32'(head_res.send_seq), 32'(seen_res.send_seq));
          check_field("send_root_clock", head_res.send_root_clock,
                      seen_res.send_root_clock);
          check_field("arm_forward", 32'(head_res.arm_forward),
                      32'(seen_res.arm_forward));
          check_field("rearm_forward", 32'(head_res.rearm_forward),
                      32'(seen_res.rearm_forward));
        end
      end
      if (in_valid && !in_stall) begin
        due_results.push_back(track_event(shown_ev));
        num_taken++;
      end
    end
  end

  // event builders for the directed part
  function rrt_item_t quiet_event(input logic [2:0] op, input logic [31:0] at,
                                  input logic [15:0] from);
    rrt_item_t ev;
    ev = '0;
    ev.operation = op;
    ev.now = at;
    ev.src_addr = from;
    return ev;
  endfunction

  function rrt_item_t advert(input logic [31:0] at, input logic [15:0] from,
                             input logic [15:0] root, input logic [7:0] hops,
                             input logic [15:0] seq, input logic [31:0] clock_val,
                             input logic full);
    rrt_item_t ev;
    ev = quiet_event(OP_ADVERT, at, from);
    ev.adv_root = root;
    ev.adv_hops = hops;
    ev.adv_seq = seq;
    ev.adv_root_clock = clock_val;
    ev.adv_complete = full;
    return ev;
  endfunction

  function rrt_item_t packet(input logic [31:0] at, input logic [15:0] dst,
                             input logic self, input logic [7:0] hl,
                             input logic [15:0] link_dst);
    rrt_item_t ev;
    ev = quiet_event(OP_PACKET, at, 16'h0000);
    ev.dst_addr = dst;
    ev.from_self = self;
    ev.hop_limit = hl;
    ev.immed_dst = link_dst;
    return ev;
  endfunction

  // random event, mostly well-formed route traffic around the current setting
  function rrt_item_t make_event();
    rrt_item_t ev;
    int pick;
    ev.src_addr = 16'($urandom);
    ev.adv_complete = 1'($urandom);
    ev.adv_root = 16'($urandom);
    ev.adv_hops = 8'($urandom);
    ev.adv_seq = 16'($urandom);
    ev.adv_root_clock = $urandom;
    ev.dst_addr = 16'($urandom);
    ev.from_self = 1'($urandom);
    ev.hop_limit = 8'($urandom);
    ev.immed_dst = 16'($urandom);
    // tick advance: standing still, small steps, jumps near expiry, or anywhere
    pick = $urandom_range(0, 99);
    if (pick < 3)
      gen_tick = $urandom;
    else if (pick < 11)
      gen_tick = gen_tick + {1'b0, plan_lifetime} + 32'($urandom_range(0, 40)) - 32'd20;
    else if (pick < 35)
      gen_tick = gen_tick;
    else
      gen_tick = gen_tick + 32'($urandom_range(1, 24));
    ev.now = gen_tick;
    // event kind
    pick = $urandom_range(0, 99);
    if (pick < 4)       ev.operation = OP_REQ_TIMER + 3'($urandom_range(1, 3));
    else if (pick < 40) ev.operation = OP_ADVERT;
    else if (pick < 50) ev.operation = OP_REQUEST;
    else if (pick < 82) ev.operation = OP_PACKET;
    else if (pick < 91) ev.operation = OP_FWD_TIMER;
    else                ev.operation = OP_REQ_TIMER;
    // sender mostly the accepted neighbour
    if ($urandom_range(0, 29) == 0) gen_peer = 16'($urandom);
    if ($urandom_range(0, 9) < 8)
      ev.src_addr = (plan_upstream != 16'd0) ? plan_upstream : gen_peer;
    // advertisement content
    if ($urandom_range(0, 9) != 0) ev.adv_complete = 1'b1;
    pick = $urandom_range(0, 9);
    if (pick < 8)       ev.adv_hops = 8'($urandom_range(0, plan_max_hops));
    else if (pick == 8) ev.adv_hops = plan_max_hops + 8'd1;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      ev.adv_seq = gen_seq;
    end else if (pick < 7) begin
      gen_seq = gen_seq + 16'($urandom_range(1, 3));
      ev.adv_seq = gen_seq;
    end else if (pick < 9) begin
      ev.adv_seq = gen_seq - 16'($urandom_range(1, 4));
    end
    if ($urandom_range(0, 19) == 0) gen_root = 16'($urandom);
    if ($urandom_range(0, 9) != 0) ev.adv_root = gen_root;
    // packet content
    pick = $urandom_range(0, 99);
    if (pick < 25)      ev.dst_addr = ADDR_ROOT_ALIAS;
    else if (pick < 50) ev.dst_addr = gen_root;
    else if (pick < 62) ev.dst_addr = plan_own;
    else if (pick < 72) ev.dst_addr = ADDR_BROADCAST;
    pick = $urandom_range(0, 99);
    if (pick < 20)      ev.hop_limit = 8'd0;
    else if (pick < 40) ev.hop_limit = 8'd1;
    else if (pick < 55) ev.hop_limit = 8'd2;
    if ($urandom_range(0, 1) == 0) ev.immed_dst = plan_own;
    return ev;
  endfunction

  task push_event(input rrt_item_t ev);
    events_to_send.push_back(ev);
    num_sent++;
  endtask

  // one register write; entered and left at a falling edge
  task write_reg(input logic [2:0] idx, input logic [31:0] data);
    int seen;
    seen = cfg_done;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (cfg_done == seen);
  endtask

  task apply_setting(input logic [15:0] own, input logic [15:0] upstream,
                     input logic [7:0] hops, input logic [30:0] lifetime);
    plan_own = own;
    plan_upstream = upstream;
    plan_max_hops = hops;
    plan_lifetime = lifetime;
    write_reg(REG_LOCAL_ADDR, {16'd0, own});
    write_reg(REG_REQ_NEXTHOP, {16'd0, upstream});
    write_reg(REG_MAX_HOPS, {24'd0, hops});
    write_reg(REG_VALID_TICKS, {1'b0, lifetime});
    cfg_valid <= 1'b0;
  endtask

  // waits until every event has transferred and every result has come back
  task wait_drained();
    do @(negedge clk); while (num_taken != num_sent || due_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task run_phase(input logic [15:0] own, input logic [15:0] upstream,
                 input logic [7:0] hops, input logic [30:0] lifetime,
                 input int offer_idle, input int recv_stall, input int count,
                 input logic squeeze);
    apply_setting(own, upstream, hops, lifetime);
    idle_pct = offer_idle;
    stall_pct = recv_stall;
    repeat (count) push_event(make_event());
    if (squeeze) hold_ask = 1'b1;
    wait_drained();
  endtask

  // main sequence
  initial begin : main_seq
    logic [31:0] t0;
    gen_tick = $urandom;
    gen_seq = 16'($urandom);
    gen_root = 16'($urandom);
    gen_peer = 16'($urandom);
    t0 = 32'hFFFF_FE00;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: every event kind and the corner cases, route expiry across the wrap
    apply_setting(16'h0010, 16'h0000, 8'd16, 31'd1000);
    push_event(quiet_event(OP_REQ_TIMER, t0, 16'h0020));
    push_event(quiet_event(OP_FWD_TIMER, t0, 16'h0020));
    push_event(quiet_event(OP_REQUEST, t0, 16'h0020));
    push_event(quiet_event(OP_REQUEST, t0, 16'h0020));
    push_event(advert(t0, 16'h0020, 16'h0001, 8'd3, 16'hFFF0, 32'hFFFF_FFFF, 1'b0));
    push_event(advert(t0, 16'h0020, 16'h0001, 8'd17, 16'hFFF0, 32'hFFFF_FFFF, 1'b1));
    push_event(advert(t0, 16'h0020, 16'h0001, 8'd3, 16'hFFF0, 32'hFFFF_FFFF, 1'b1));
    push_event(quiet_event(OP_FWD_TIMER, t0 + 32'd5, 16'h0000));
    push_event(advert(t0 + 32'd6, 16'h0020, 16'h0001, 8'd2, 16'hFFF0, 32'h1234_5678, 1'b1));
    push_event(advert(t0 + 32'd7, 16'h0021, 16'h0001, 8'd2, 16'hFFF0, 32'h0000_0000, 1'b1));
    push_event(advert(t0 + 32'd8, 16'h0020, 16'h0001, 8'd9, 16'h0005, 32'h8000_0000, 1'b1));
    push_event(advert(t0 + 32'd9, 16'hFFFF, 16'hFFFF, 8'd1, 16'hFFF0, 32'hFFFF_FFFF, 1'b1));
    push_event(quiet_event(OP_REQ_TIMER, t0 + 32'd10, 16'h0000));
    push_event(packet(t0 + 32'd11, ADDR_ROOT_ALIAS, 1'b1, 8'd0, 16'h0000));
    push_event(packet(t0 + 32'd12, 16'h0001, 1'b0, 8'd1, 16'h0010));
    push_event(packet(t0 + 32'd13, 16'h0001, 1'b0, 8'd0, 16'hFFFF));
    push_event(packet(t0 + 32'd14, 16'h0010, 1'b0, 8'd255, 16'h0010));
    push_event(packet(t0 + 32'd15, ADDR_BROADCAST, 1'b1, 8'd7, 16'hFFFF));
    push_event(packet(t0 + 32'd16, ADDR_BROADCAST, 1'b0, 8'd7, 16'hFFFF));
    push_event(packet(t0 + 32'd17, 16'h4321, 1'b0, 8'd255, 16'h0010));
    push_event(packet(t0 + 32'd18, 16'hBEEF, 1'b1, 8'd0, 16'h0010));
    for (int k = OP_REQ_TIMER + 1; k < 8; k++)
      push_event(quiet_event(3'(k), t0 + 32'd19, 16'h0020));
    push_event(packet(t0 + 32'd1200, 16'h0001, 1'b0, 8'd5, 16'h0010));
    push_event(quiet_event(OP_REQ_TIMER, t0 + 32'd1200, 16'h0000));
    wait_drained();

    // random phases across settings and flow-control patterns
    run_phase(16'h0010, 16'h0000, 8'd16, 31'd1000, 0, 0, 240, 1'b0);
    run_phase(16'h0000, 16'h0020, 8'd1, 31'd1, 86, 0, 240, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 8'd254, 31'h7FFF_FFFF, 0, 86, 240, 1'b0);
    run_phase(16'h1234, 16'h0020, 8'd8, 31'd500, 35, 35, 240, 1'b1);
    run_phase(16'($urandom), 16'h0000, 8'($urandom_range(1, 254)),
              31'($urandom_range(1, 3000)), 0, 0, 240, 1'b1);
    run_phase(16'h0010, 16'h0000, MAX_HOPS_RST, VALID_TICKS_RST, 0, 0, 240, 1'b0);

    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("root_route_tracker: match");
    end else begin
      $display("root_route_tracker: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("root_route_tracker: mismatch");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/rrt_pkg.sv
hw/rtl/rrt_cfg_regs.sv
hw/rtl/rrt_route_core.sv
hw/rtl/root_route_tracker.sv
hw/rtl/rrt_checker.sv
sim/tb_root_route_tracker.sv
